>>> rtl/rims_pkg.sv
// ----------------------------------------------------------------------------
// Run insertion merge sorter package
// Shared constants, codes and the controller to datapath command and status
// words.
// ----------------------------------------------------------------------------
package rims_pkg;

  localparam int DEF_MAX_ITEMS  = 1024;
  localparam int DEF_VALUE_BITS = 32;
  localparam int POS_BITS       = 10;
  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_RUN  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_RUN   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_SWITCH = 2'd2;

  localparam logic [CFG_BITS-1:0] RESET_SHORT_RUN  = 11'd32;
  localparam logic [CFG_BITS-1:0] RESET_LONG_RUN   = 11'd64;
  localparam logic [CFG_BITS-1:0] RESET_RUN_SWITCH = 11'd300;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic accept_load;
    logic accept_read;
    logic setup;
    logic run_begin;
    logic run_end;
    logic ins_fetch;
    logic ins_key;
    logic ins_peek;
    logic ins_shift;
    logic ins_put;
    logic msize_init;
    logic mpass_init;
    logic mpass_next;
    logic mpair_init;
    logic rd_a;
    logic cap_a_rd_b;
    logic take_a;
    logic take_b;
    logic cap_a;
    logic cap_b;
    logic cp_init;
    logic cp_read;
    logic cp_write;
    logic pair_next;
  } cmd_t;

  typedef struct packed {
    logic run_done;
    logic ins_done;
    logic j_gt_lo;
    logic gt;
    logic size_done;
    logic pair_done;
    logic a_ok;
    logic b_ok;
    logic a_le_b;
    logic cp_done;
  } sts_t;

endpackage

>>> rtl/run_insertion_merge_sorter.sv
// ----------------------------------------------------------------------------
// Run insertion merge sorter
// Loads signed values, sorts them with run insertion sort and bottom-up merge,
// and returns values by sorted position.
// ----------------------------------------------------------------------------
// A word is accepted at a clock edge where start is high and busy is low.
// kind selects a load or a read. Loads give no result; a load with last set
// starts the sort, and busy stays high until it ends. The element store and
// the scratch memory each have one read and one write port.
// A read returns its result in the cycle after acceptance: result_valid is high
// for exactly that cycle with sorted_value, read_position, beyond_count and
// overflowed. Reads and loads can be issued every cycle while idle.
// The receiver cannot stall; every result is taken in its cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// Reset clears the count, the overflow flag and restores the run lengths.
// ----------------------------------------------------------------------------
module run_insertion_merge_sorter import rims_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [POS_BITS-1:0]          position,
  input  logic                         last,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  output logic                         result_valid,
  output logic signed [VALUE_BITS-1:0] sorted_value,
  output logic [POS_BITS-1:0]          read_position,
  output logic                         beyond_count,
  output logic                         overflowed
);

  cmd_t cmd;
  sts_t sts;

  rims_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .last  (last),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rims_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .value         (value),
    .position      (position),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .sorted_value  (sorted_value),
    .read_position (read_position),
    .beyond_count  (beyond_count),
    .overflowed    (overflowed)
  );

endmodule

>>> rtl/rims_ctrl.sv
// ----------------------------------------------------------------------------
// Run insertion merge sorter controller
// Sequences loads, reads, the run insertion sort and the bottom-up merge.
// ----------------------------------------------------------------------------
module rims_ctrl import rims_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  logic last,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_SETUP      = 5'd1;
  localparam logic [4:0] S_RUN_CHK    = 5'd2;
  localparam logic [4:0] S_INS_CHK    = 5'd3;
  localparam logic [4:0] S_INS_KEY    = 5'd4;
  localparam logic [4:0] S_INS_TEST   = 5'd5;
  localparam logic [4:0] S_INS_CMP    = 5'd6;
  localparam logic [4:0] S_INS_PUT    = 5'd7;
  localparam logic [4:0] S_MSIZE_INIT = 5'd8;
  localparam logic [4:0] S_MSIZE_CHK  = 5'd9;
  localparam logic [4:0] S_MPAIR_CHK  = 5'd10;
  localparam logic [4:0] S_MRD_A      = 5'd11;
  localparam logic [4:0] S_MRD_B      = 5'd12;
  localparam logic [4:0] S_MSEL       = 5'd13;
  localparam logic [4:0] S_MCAPA      = 5'd14;
  localparam logic [4:0] S_MCAPB      = 5'd15;
  localparam logic [4:0] S_CP_RD      = 5'd16;
  localparam logic [4:0] S_CP_WR      = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_LOAD) begin
            cmd.accept_load = 1'b1;
            if (last) begin
              state_next = S_SETUP;
            end
          end else begin
            cmd.accept_read = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_RUN_CHK;
      end
      S_RUN_CHK: begin
        if (sts.run_done) begin
          state_next = S_MSIZE_INIT;
        end else begin
          cmd.run_begin = 1'b1;
          state_next    = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts.ins_done) begin
          cmd.run_end = 1'b1;
          state_next  = S_RUN_CHK;
        end else begin
          cmd.ins_fetch = 1'b1;
          state_next    = S_INS_KEY;
        end
      end
      S_INS_KEY: begin
        cmd.ins_key = 1'b1;
        state_next  = S_INS_TEST;
      end
      S_INS_TEST: begin
        if (sts.j_gt_lo) begin
          cmd.ins_peek = 1'b1;
          state_next   = S_INS_CMP;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_CMP: begin
        if (sts.gt) begin
          cmd.ins_shift = 1'b1;
          state_next    = S_INS_TEST;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_next  = S_INS_CHK;
      end
      S_MSIZE_INIT: begin
        cmd.msize_init = 1'b1;
        state_next     = S_MSIZE_CHK;
      end
      S_MSIZE_CHK: begin
        if (sts.size_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.mpass_init = 1'b1;
          state_next     = S_MPAIR_CHK;
        end
      end
      S_MPAIR_CHK: begin
        if (sts.pair_done) begin
          cmd.mpass_next = 1'b1;
          state_next     = S_MSIZE_CHK;
        end else begin
          cmd.mpair_init = 1'b1;
          state_next     = S_MRD_A;
        end
      end
      S_MRD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = S_MRD_B;
      end
      S_MRD_B: begin
        cmd.cap_a_rd_b = 1'b1;
        state_next     = S_MCAPB;
      end
      S_MSEL: begin
        if (sts.a_ok && (!sts.b_ok || sts.a_le_b)) begin
          cmd.take_a = 1'b1;
          state_next = S_MCAPA;
        end else if (sts.b_ok) begin
          cmd.take_b = 1'b1;
          state_next = S_MCAPB;
        end else begin
          cmd.cp_init = 1'b1;
          state_next  = S_CP_RD;
        end
      end
      S_MCAPA: begin
        cmd.cap_a  = 1'b1;
        state_next = S_MSEL;
      end
      S_MCAPB: begin
        cmd.cap_b  = 1'b1;
        state_next = S_MSEL;
      end
      S_CP_RD: begin
        if (sts.cp_done) begin
          cmd.pair_next = 1'b1;
          state_next    = S_MPAIR_CHK;
        end else begin
          cmd.cp_read = 1'b1;
          state_next  = S_CP_WR;
        end
      end
      S_CP_WR: begin
        cmd.cp_write = 1'b1;
        state_next   = S_CP_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept_load && last) |=> busy)
    else $error("sort did not start after the last load");
  a_merge_exhausted: assert property (@(posedge clk) disable iff (rst)
    (state == S_MSEL && !sts.a_ok && !sts.b_ok) |=> (state == S_CP_RD))
    else $error("merge did not move to copy back");
`endif

endmodule

>>> rtl/rims_dp.sv
// ----------------------------------------------------------------------------
// Run insertion merge sorter datapath
// Element store, merge scratch, index registers, comparators and the
// configuration and result registers.
// ----------------------------------------------------------------------------
module rims_dp import rims_pkg::*; #(
  parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [POS_BITS-1:0]       position,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  output logic                      result_valid,
  output logic signed [VALUE_BITS-1:0] sorted_value,
  output logic [POS_BITS-1:0]       read_position,
  output logic                      beyond_count,
  output logic                      overflowed
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = ((CW > CFG_BITS) ? CW : CFG_BITS) + 2;

  logic [VALUE_BITS-1:0] store_mem [MAX_ITEMS];
  logic [VALUE_BITS-1:0] scratch_mem [MAX_ITEMS];

  logic [CFG_BITS-1:0]   short_run;
  logic [CFG_BITS-1:0]   long_run;
  logic [CFG_BITS-1:0]   run_switch;
  logic [CW-1:0]         count;
  logic                  ovf;
  logic [VALUE_BITS-1:0] rd;
  logic [VALUE_BITS-1:0] sd;
  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS-1:0] va;
  logic [VALUE_BITS-1:0] vb;
  logic [XW-1:0]         run;
  logic [XW-1:0]         lo;
  logic [XW-1:0]         hi;
  logic [XW-1:0]         i;
  logic [XW-1:0]         j;
  logic [XW-1:0]         size;
  logic [XW-1:0]         a;
  logic [XW-1:0]         b;
  logic [XW-1:0]         k;
  logic [XW-1:0]         mid;
  logic                  beyond_r;

  logic [XW-1:0]         n;
  logic [XW-1:0]         posx;
  logic [XW-1:0]         lo_run;
  logic [XW-1:0]         lo_size;
  logic [XW-1:0]         lo_2size;
  logic [XW-1:0]         run_sel;
  logic                  st_we;
  logic [AW-1:0]         st_wa;
  logic [VALUE_BITS-1:0] st_wd;
  logic [AW-1:0]         st_ra;
  logic                  full;

  assign n        = XW'(count);
  assign posx     = XW'(position);
  assign lo_run   = lo + run;
  assign lo_size  = lo + size;
  assign lo_2size = lo_size + size;
  assign run_sel  = (n < XW'(run_switch)) ? XW'(short_run) : XW'(long_run);
  assign full     = (count == CW'(MAX_ITEMS));

  assign sts.run_done  = (lo >= n);
  assign sts.ins_done  = (i >= hi);
  assign sts.j_gt_lo   = (j > lo);
  assign sts.gt        = ($signed(rd) > $signed(key));
  assign sts.size_done = (size >= n);
  assign sts.pair_done = (lo_size >= n);
  assign sts.a_ok      = (a < mid);
  assign sts.b_ok      = (b < hi);
  assign sts.a_le_b    = ($signed(va) <= $signed(vb));
  assign sts.cp_done   = (k >= hi);

  always_comb begin
    st_we = 1'b0;
    st_wa = count[AW-1:0];
    st_wd = value;
    st_ra = posx[AW-1:0];
    if (cmd.accept_load && !full) begin
      st_we = 1'b1;
    end
    if (cmd.ins_shift) begin
      st_we = 1'b1;
      st_wa = j[AW-1:0];
      st_wd = rd;
    end
    if (cmd.ins_put) begin
      st_we = 1'b1;
      st_wa = j[AW-1:0];
      st_wd = key;
    end
    if (cmd.cp_write) begin
      st_we = 1'b1;
      st_wa = k[AW-1:0];
      st_wd = sd;
    end
    if (cmd.ins_fetch) begin
      st_ra = i[AW-1:0];
    end
    if (cmd.ins_peek) begin
      st_ra = AW'(j - XW'(1));
    end
    if (cmd.rd_a) begin
      st_ra = a[AW-1:0];
    end
    if (cmd.cap_a_rd_b) begin
      st_ra = b[AW-1:0];
    end
    if (cmd.take_a) begin
      st_ra = AW'(a + XW'(1));
    end
    if (cmd.take_b) begin
      st_ra = AW'(b + XW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    rd <= store_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_a) begin
      scratch_mem[k[AW-1:0]] <= va;
    end else if (cmd.take_b) begin
      scratch_mem[k[AW-1:0]] <= vb;
    end
    if (cmd.cp_read) begin
      sd <= scratch_mem[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_run    <= RESET_SHORT_RUN;
      long_run     <= RESET_LONG_RUN;
      run_switch   <= RESET_RUN_SWITCH;
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHORT_RUN:  short_run  <= cfg_data;
          REG_LONG_RUN:   long_run   <= cfg_data;
          REG_RUN_SWITCH: run_switch <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept_load) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      result_valid <= cmd.accept_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_read) begin
      read_position <= position;
      beyond_r      <= (posx >= n);
      overflowed    <= ovf;
    end
    if (cmd.setup) begin
      run <= (run_sel == '0) ? XW'(1) : run_sel;
      lo  <= '0;
    end
    if (cmd.run_begin) begin
      hi <= (lo_run > n) ? n : lo_run;
      i  <= lo + XW'(1);
    end
    if (cmd.run_end) begin
      lo <= hi;
    end
    if (cmd.ins_fetch) begin
      j <= i;
    end
    if (cmd.ins_key) begin
      key <= rd;
    end
    if (cmd.ins_shift) begin
      j <= j - XW'(1);
    end
    if (cmd.ins_put) begin
      i <= i + XW'(1);
    end
    if (cmd.msize_init) begin
      size <= run;
    end
    if (cmd.mpass_init) begin
      lo <= '0;
    end
    if (cmd.mpass_next) begin
      size <= size << 1;
    end
    if (cmd.mpair_init) begin
      mid <= lo_size;
      hi  <= (lo_2size > n) ? n : lo_2size;
      a   <= lo;
      b   <= lo_size;
      k   <= lo;
    end
    if (cmd.cap_a_rd_b || cmd.cap_a) begin
      va <= rd;
    end
    if (cmd.cap_b) begin
      vb <= rd;
    end
    if (cmd.take_a) begin
      a <= a + XW'(1);
      k <= k + XW'(1);
    end
    if (cmd.take_b) begin
      b <= b + XW'(1);
      k <= k + XW'(1);
    end
    if (cmd.cp_init) begin
      k <= lo;
    end
    if (cmd.cp_write) begin
      k <= k + XW'(1);
    end
    if (cmd.pair_next) begin
      lo <= lo_2size;
    end
  end

  assign beyond_count = beyond_r;
  assign sorted_value = beyond_r ? '0 : $signed(rd);

`ifndef ASSERT_OFF
  a_result_follows_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.accept_read))
    else $error("result word without a read");
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (XW'(count) <= XW'(MAX_ITEMS)))
    else $error("element count beyond capacity");
`endif

endmodule

>>> dv/sort_result_checker.sv
// ----------------------------------------------------------------------------
// Sorter result checker
// Watches the command, configuration and result ports of the sorter, keeps
// its own copy of the stored values and run settings, sorts them the way the
// block does when a last load is accepted, and compares every read result.
// ----------------------------------------------------------------------------
module sort_result_checker import rims_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      kind,
  input  logic signed [31:0]        value,
  input  logic [POS_BITS-1:0]       position,
  input  logic                      last,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      result_valid,
  input  logic signed [31:0]        sorted_value,
  input  logic [POS_BITS-1:0]       read_position,
  input  logic                      beyond_count,
  input  logic                      overflowed,
  output int                        mismatches,
  output int                        pending,
  output int                        reads_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0]  val;
    logic [POS_BITS-1:0] pos;
    logic                beyond;
    logic                ovf;
  } read_word_t;

  logic signed [31:0] vals [DEF_MAX_ITEMS];
  logic signed [31:0] scratch [DEF_MAX_ITEMS];
  int unsigned count;
  logic ovf_flag;
  int unsigned short_len, long_len, switch_cnt;
  read_word_t read_q [$];

  task automatic flag_error(input string what, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
    end
    mismatches++;
  endtask

  task automatic sort_values();
    int n, run, lo, hi, i, j, sz, mid, a, b, k;
    logic signed [31:0] t;
    n = count;
    run = (count < switch_cnt) ? short_len : long_len;
    if (run == 0) begin
      run = 1;
    end
    for (lo = 0; lo < n; lo += run) begin
      hi = (n - lo > run) ? lo + run : n;
      for (i = lo + 1; i < hi; i++) begin
        j = i;
        while (j > lo && vals[j] < vals[j-1]) begin
          t = vals[j];
          vals[j] = vals[j-1];
          vals[j-1] = t;
          j--;
        end
      end
    end
    for (sz = run; sz < n; sz *= 2) begin
      for (lo = 0; lo < n; lo += 2 * sz) begin
        if (n - lo <= sz) break;
        mid = lo + sz;
        hi = (n - mid > sz) ? mid + sz : n;
        a = lo;
        b = mid;
        k = lo;
        while (a < mid && b < hi) begin
          if (vals[a] <= vals[b]) begin
            scratch[k++] = vals[a++];
          end else begin
            scratch[k++] = vals[b++];
          end
        end
        while (a < mid) scratch[k++] = vals[a++];
        while (b < hi) scratch[k++] = vals[b++];
        for (k = lo; k < hi; k++) vals[k] = scratch[k];
      end
    end
  endtask

  always @(posedge clk) begin
    read_word_t w, got;
    if (rst) begin
      count = 0;
      ovf_flag = 1'b0;
      short_len = 32'(RESET_SHORT_RUN);
      long_len = 32'(RESET_LONG_RUN);
      switch_cnt = 32'(RESET_RUN_SWITCH);
      read_q.delete();
      mismatches = 0;
      reads_checked = 0;
    end else begin
      if (result_valid) begin
        if (read_q.size() == 0) begin
          flag_error("unexpected word", 32'h0, sorted_value);
        end else begin
          w = read_q.pop_front();
          reads_checked++;
          if (sorted_value !== w.val) flag_error("sorted_value", w.val, sorted_value);
          if (read_position !== w.pos) begin
            flag_error("read_position", 32'(w.pos), 32'(read_position));
          end
          if (beyond_count !== w.beyond) begin
            flag_error("beyond_count", 32'(w.beyond), 32'(beyond_count));
          end
          if (overflowed !== w.ovf) begin
            flag_error("overflowed", 32'(w.ovf), 32'(overflowed));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SHORT_RUN:  short_len = 32'(cfg_data);
          REG_LONG_RUN:   long_len = 32'(cfg_data);
          REG_RUN_SWITCH: switch_cnt = 32'(cfg_data);
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (kind == KIND_LOAD) begin
          if (count < DEF_MAX_ITEMS) begin
            vals[count] = value;
            count++;
          end else begin
            ovf_flag = 1'b1;
          end
          if (last) sort_values();
        end else begin
          got.pos = position;
          got.ovf = ovf_flag;
          got.beyond = (position >= count);
          got.val = got.beyond ? 32'sd0 : vals[position];
          read_q.push_back(got);
        end
      end
    end
    pending = read_q.size();
  end

endmodule

>>> dv/run_insertion_merge_sorter_tb.sv
// ----------------------------------------------------------------------------
// Run insertion merge sorter testbench
// Loads signed values in batches under a range of run settings, sorts them,
// and reads back sorted positions, with random gaps between words until the
// last batch. A checker beside the block predicts and checks every read word.
// ----------------------------------------------------------------------------
module run_insertion_merge_sorter_tb;
  import rims_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst, start, busy, kind, last, cfg_we;
  logic signed [31:0] value, sorted_value;
  logic [POS_BITS-1:0] position, read_position;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;
  logic result_valid, beyond_count, overflowed;
  int mismatches, pending, reads_checked;
  int loads_sent, sorts_sent, stored;
  bit gaps_on;

  run_insertion_merge_sorter u_top (
    .clk, .rst, .start, .busy, .kind, .value, .position, .last,
    .cfg_we, .cfg_index, .cfg_data,
    .result_valid, .sorted_value, .read_position, .beyond_count, .overflowed
  );

  sort_result_checker u_checker (
    .clk, .rst, .start, .busy, .kind, .value, .position, .last,
    .cfg_we, .cfg_index, .cfg_data,
    .result_valid, .sorted_value, .read_position, .beyond_count, .overflowed,
    .mismatches, .pending, .reads_checked
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic k, input logic signed [31:0] v,
                           input logic [POS_BITS-1:0] p, input logic l);
    start <= 1'b1;
    kind <= k;
    value <= v;
    position <= p;
    last <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (k == KIND_LOAD) begin
      loads_sent++;
      if (stored < DEF_MAX_ITEMS) stored++;
      if (l) sorts_sent++;
    end
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic load(input logic signed [31:0] v, input logic l);
    send_word(KIND_LOAD, v, POS_BITS'($urandom), l);
  endtask

  task automatic read_at(input logic [POS_BITS-1:0] p);
    send_word(KIND_READ, $urandom, p, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    repeat (3) @(negedge clk);
    while (busy || pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic set_runs(input int s, input int l, input int sw);
    wait_idle();
    write_reg(REG_SHORT_RUN, CFG_BITS'(s));
    write_reg(REG_LONG_RUN, CFG_BITS'(l));
    write_reg(REG_RUN_SWITCH, CFG_BITS'(sw));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int short_tab [3] = '{1024, 0, 0};
    int long_tab [3] = '{1, 1024, 7};
    int switch_tab [3] = '{1024, 0, 1024};
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_LOAD;
    value = '0;
    position = '0;
    last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    loads_sent = 0;
    sorts_sent = 0;
    stored = 0;
    gaps_on = 1'b1;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    read_at('0);
    read_at(POS_BITS'(1023));
    load(32'sh7fffffff, 1'b0);
    load(32'sh80000000, 1'b0);
    load(32'sd0, 1'b0);
    load(-32'sd1, 1'b0);
    load(32'sh80000000, 1'b0);
    for (int i = 0; i < 6; i++) read_at(POS_BITS'(i));
    load(32'sd5, 1'b1);
    for (int i = 0; i < 7; i++) read_at(POS_BITS'(i));

    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        set_runs(short_tab[ph], long_tab[ph], switch_tab[ph]);
      end else begin
        set_runs($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 1024));
      end
      gaps_on = (ph < 8);
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 7) == 0) read_at(POS_BITS'($urandom));
        load(pick_value(), (i == 119) || ($urandom_range(0, 59) == 0));
      end
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 4) == 0) read_at(POS_BITS'($urandom));
        else read_at(POS_BITS'($urandom_range(0, stored - 1)));
      end
    end

    start <= 1'b0;
    while (busy || pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Loaded %0d values (%0d kept) over %0d sorts, checked %0d read words.",
             loads_sent, stored, sorts_sent, reads_checked);
    $display("Run lengths covered zero, one, small values and the full store.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rims_pkg.sv
rtl/rims_ctrl.sv
rtl/rims_dp.sv
rtl/run_insertion_merge_sorter.sv
dv/sort_result_checker.sv
dv/run_insertion_merge_sorter_tb.sv
